@@ hdl/ffsa_pkg.sv @@
// Shared types, constants and helper functions of the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF = 64;
    localparam logic [31:0] PAGE_SIZE_RESET  = 32'd134217728;

    localparam int unsigned OFF_W  = 32;
    localparam int unsigned SIZE_W = 33;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned REQ_W  = 32;
    localparam int unsigned GRAN_W = 17;
    localparam int unsigned PAD_W  = 35;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 2'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } seg_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  given_id;
        logic [OFF_W-1:0] offset;
    } res_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_LOAD,
        ST_A_CHK,
        ST_A_PAD,
        ST_A_FIT,
        ST_A_ADV,
        ST_A_SPLIT,
        ST_A_DONE,
        ST_F_SCAN,
        ST_F_MERGE,
        ST_F_ADD,
        ST_F_DONE,
        ST_MOVE,
        ST_RESP
    } fsm_state_t;

    function automatic logic [PAD_W-1:0] align_up(input logic [PAD_W-1:0] x,
                                                  input logic [GRAN_W-1:0] a);
        logic [PAD_W-1:0] am1;
        am1 = (a == '0) ? '0 : PAD_W'(a - GRAN_W'(1));
        return (x + am1) & ~am1;
    endfunction

    // true when the last byte of a lies in the same granularity page as b
    function automatic logic same_page(input logic [PAD_W-1:0] a_off,
                                       input logic [PAD_W-1:0] a_size,
                                       input logic [PAD_W-1:0] b_off,
                                       input logic [GRAN_W-1:0] g);
        logic [PAD_W:0] last;
        logic [PAD_W:0] mask;
        last = {1'b0, a_off} + {1'b0, a_size};
        mask = ~((PAD_W+1)'(g) - (PAD_W+1)'(1));
        return (last != '0) &&
               (((last - (PAD_W+1)'(1)) & mask) == ({1'b0, b_off} & mask));
    endfunction

endpackage
`default_nettype wire

@@ hdl/first_fit_segment_allocator.sv @@
// Top level of the first-fit segment allocator with coalescing.
// Allocation walks the table, skipping segments that are used, too small, or not fitting after
// padding; on a split the entries above are moved up one place before the new free entry is written.
// No fit ends after the last entry. Free scans for the id, then moves the entries above the merge down;
// an unknown id scans the whole table. Flow: one word in flight; the next is accepted once the result registers.
// Reset: synchronous, active low; entry 0 written in the cycle after reset or a page_size write.
`default_nettype none
module first_fit_segment_allocator #(
    parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [ffsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ffsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // request_size[31:0], alignment[48:32], block_id[80:49], zero pad
    input  wire logic [ffsa_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], given_id[33:2], offset[65:34], zero pad
    output logic [ffsa_pkg::OUT_DATA_W-1:0]        m_tdata
);
    localparam int unsigned AW = $clog2(MAX_SEGMENTS);

    logic                     res_valid;
    ffsa_pkg::res_t           res;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    ffsa_pkg::seg_t           mem_wdata, mem_rdata;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [ffsa_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    ffsa_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_size   (s_tdata[31:0]),
        .in_align  (s_tdata[48:32]),
        .in_id     (s_tdata[80:49]),
        .res_free  (!m_tvalid_reg || m_tready),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ffsa_mem #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res.offset, res.given_id, res.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

@@ hdl/ffsa_mem.sv @@
// Segment table memory: one write port, one read port, registered read data.
`default_nettype none
module ffsa_mem #(
    parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            we,
    input  wire logic [$clog2(MAX_SEGMENTS)-1:0] waddr,
    input  wire ffsa_pkg::seg_t                  wdata,
    input  wire logic [$clog2(MAX_SEGMENTS)-1:0] raddr,
    output ffsa_pkg::seg_t                       rdata
);
    ffsa_pkg::seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/ffsa_ctrl.sv @@
// Sequencer: first-fit search, split, free with merge, and table entry moves.
`default_nettype none
module ffsa_ctrl #(
    parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [ffsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ffsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 in_func,
    input  wire logic [ffsa_pkg::REQ_W-1:0]           in_size,
    input  wire logic [ffsa_pkg::GRAN_W-1:0]          in_align,
    input  wire logic [ffsa_pkg::ID_W-1:0]            in_id,
    input  wire logic                                 res_free,
    output logic                                      res_valid,
    output ffsa_pkg::res_t                            res,
    output logic                                      mem_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0]           mem_waddr,
    output ffsa_pkg::seg_t                            mem_wdata,
    output logic [$clog2(MAX_SEGMENTS)-1:0]           mem_raddr,
    input  wire ffsa_pkg::seg_t                       mem_rdata
);
    localparam int unsigned AW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned PW = ffsa_pkg::PAD_W;

    ffsa_pkg::fsm_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [ffsa_pkg::ID_W-1:0] idc_reg, idc_next;
    logic [31:0] page_reg, page_next;
    logic [ffsa_pkg::GRAN_W-1:0] gran_reg, gran_next;

    logic [ffsa_pkg::REQ_W-1:0] req_reg, req_next;
    logic [ffsa_pkg::GRAN_W-1:0] al_reg, al_next;
    logic [ffsa_pkg::ID_W-1:0] bid_reg, bid_next;
    logic [CW-1:0] idx_reg, idx_next;
    ffsa_pkg::seg_t cur_reg, cur_next, prev_reg, prev_next, nxt_reg, nxt_next;
    ffsa_pkg::seg_t tent_reg, tent_next;
    logic [AW-1:0] t_reg, t_next;
    logic nm_reg, nm_next;
    logic [1:0] rm_reg, rm_next;
    logic [PW-1:0] pad_reg, pad_next, padded_reg, padded_next;
    ffsa_pkg::res_t res_reg, res_next;

    logic [CW-1:0] mv_rd_reg, mv_rd_next, mv_cnt_reg, mv_cnt_next;
    logic [AW-1:0] mv_wa_reg, mv_wa_next;
    logic mv_pend_reg, mv_pend_next, mv_up_reg, mv_up_next, mv_fr_reg, mv_fr_next;

    logic [CW-1:0] idx_inc;
    logic          has_next;
    logic [PW-1:0] padded;
    logic          fail_fit;
    logic          split;
    logic          pm, nm;
    logic [CW-1:0] src_lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffsa_pkg::ST_INIT;
            count_reg   <= CW'(1);
            idc_reg     <= ffsa_pkg::ID_W'(1);
            page_reg    <= ffsa_pkg::PAGE_SIZE_RESET;
            gran_reg    <= ffsa_pkg::GRAN_W'(1);
            mv_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idc_reg     <= idc_next;
            page_reg    <= page_next;
            gran_reg    <= gran_next;
            mv_pend_reg <= mv_pend_next;
        end
        req_reg    <= req_next;
        al_reg     <= al_next;
        bid_reg    <= bid_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        tent_reg   <= tent_next;
        t_reg      <= t_next;
        nm_reg     <= nm_next;
        rm_reg     <= rm_next;
        pad_reg    <= pad_next;
        padded_reg <= padded_next;
        res_reg    <= res_next;
        mv_rd_reg  <= mv_rd_next;
        mv_cnt_reg <= mv_cnt_next;
        mv_wa_reg  <= mv_wa_next;
        mv_up_reg  <= mv_up_next;
        mv_fr_reg  <= mv_fr_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idc_next     = idc_reg;
        page_next    = page_reg;
        gran_next    = gran_reg;
        req_next     = req_reg;
        al_next      = al_reg;
        bid_next     = bid_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        tent_next    = tent_reg;
        t_next       = t_reg;
        nm_next      = nm_reg;
        rm_next      = rm_reg;
        pad_next     = pad_reg;
        padded_next  = padded_reg;
        res_next     = res_reg;
        mv_rd_next   = mv_rd_reg;
        mv_cnt_next  = mv_cnt_reg;
        mv_wa_next   = mv_wa_reg;
        mv_pend_next = mv_pend_reg;
        mv_up_next   = mv_up_reg;
        mv_fr_next   = mv_fr_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = res_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg[AW-1:0];
        mem_wdata = cur_reg;
        mem_raddr = '0;

        idx_inc  = idx_reg + CW'(1);
        has_next = idx_inc < count_reg;
        padded   = PW'(req_reg) + pad_reg - PW'(cur_reg.offset);
        fail_fit = (padded > PW'(cur_reg.size)) ||
                   ((gran_reg > ffsa_pkg::GRAN_W'(1)) && has_next &&
                    ffsa_pkg::same_page(pad_reg, PW'(req_reg), PW'(nxt_reg.offset), gran_reg));
        split    = PW'(cur_reg.size) > padded;
        pm       = (idx_reg != '0) && prev_reg.free;
        nm       = has_next && mem_rdata.free;
        src_lo   = idx_inc + CW'(nm);

        case (state_reg)
            ffsa_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{id: '0, free: 1'b1, size: ffsa_pkg::SIZE_W'(page_reg),
                              offset: '0};
                state_next = ffsa_pkg::ST_IDLE;
            end
            ffsa_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next = in_size;
                    al_next  = in_align;
                    bid_next = in_id;
                    idx_next = '0;
                    state_next = (in_func == ffsa_pkg::FUNC_FREE) ? ffsa_pkg::ST_F_SCAN
                                                                 : ffsa_pkg::ST_A_LOAD;
                end
            end
            ffsa_pkg::ST_A_LOAD: begin
                cur_next   = mem_rdata;
                state_next = ffsa_pkg::ST_A_CHK;
            end
            ffsa_pkg::ST_A_CHK: begin
                mem_raddr = idx_inc[AW-1:0];
                pad_next  = ffsa_pkg::align_up(PW'(cur_reg.offset), al_reg);
                if (!cur_reg.free || ({1'b0, req_reg} > cur_reg.size)) begin
                    state_next = ffsa_pkg::ST_A_ADV;
                end else begin
                    state_next = ffsa_pkg::ST_A_PAD;
                end
            end
            ffsa_pkg::ST_A_PAD: begin
                nxt_next = mem_rdata;
                if ((idx_reg != '0) && (gran_reg > ffsa_pkg::GRAN_W'(1)) &&
                    ffsa_pkg::same_page(PW'(prev_reg.offset), PW'(prev_reg.size),
                                        pad_reg, gran_reg)) begin
                    pad_next = ffsa_pkg::align_up(pad_reg, gran_reg);
                end
                state_next = ffsa_pkg::ST_A_FIT;
            end
            ffsa_pkg::ST_A_FIT: begin
                padded_next = padded;
                if (fail_fit) begin
                    state_next = ffsa_pkg::ST_A_ADV;
                end else if (!split) begin
                    state_next = ffsa_pkg::ST_A_DONE;
                end else if (count_reg >= CW'(MAX_SEGMENTS)) begin
                    res_next   = '{status: ffsa_pkg::STATUS_FULL, given_id: '0, offset: '0};
                    state_next = ffsa_pkg::ST_RESP;
                end else begin
                    mv_rd_next   = count_reg - CW'(1);
                    mv_cnt_next  = count_reg - idx_inc;
                    mv_up_next   = 1'b0;
                    mv_fr_next   = 1'b0;
                    mv_pend_next = 1'b0;
                    state_next   = ffsa_pkg::ST_MOVE;
                end
            end
            ffsa_pkg::ST_A_ADV: begin
                prev_next = cur_reg;
                if (!has_next) begin
                    res_next   = '{status: ffsa_pkg::STATUS_NO_FIT, given_id: '0, offset: '0};
                    state_next = ffsa_pkg::ST_RESP;
                end else begin
                    idx_next   = idx_inc;
                    mem_raddr  = idx_inc[AW-1:0];
                    state_next = ffsa_pkg::ST_A_LOAD;
                end
            end
            ffsa_pkg::ST_A_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc[AW-1:0];
                mem_wdata = '{id: idc_reg, free: 1'b1,
                              size: cur_reg.size - ffsa_pkg::SIZE_W'(padded_reg),
                              offset: cur_reg.offset + ffsa_pkg::OFF_W'(padded_reg)};
                idc_next   = idc_reg + ffsa_pkg::ID_W'(1);
                count_next = count_reg + CW'(1);
                state_next = ffsa_pkg::ST_A_DONE;
            end
            ffsa_pkg::ST_A_DONE: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = '{id: cur_reg.id, free: 1'b0,
                              size: ffsa_pkg::SIZE_W'(padded_reg), offset: cur_reg.offset};
                res_next  = '{status: ffsa_pkg::STATUS_OK, given_id: cur_reg.id,
                              offset: ffsa_pkg::OFF_W'(pad_reg)};
                state_next = ffsa_pkg::ST_RESP;
            end
            ffsa_pkg::ST_F_SCAN: begin
                mem_raddr = idx_inc[AW-1:0];
                if (mem_rdata.id == bid_reg) begin
                    cur_next   = mem_rdata;
                    state_next = ffsa_pkg::ST_F_MERGE;
                end else if (!has_next) begin
                    res_next   = '{status: ffsa_pkg::STATUS_NOT_FOUND, given_id: '0,
                                   offset: '0};
                    state_next = ffsa_pkg::ST_RESP;
                end else begin
                    prev_next = mem_rdata;
                    idx_next  = idx_inc;
                end
            end
            ffsa_pkg::ST_F_MERGE: begin
                nxt_next = mem_rdata;
                nm_next  = nm;
                rm_next  = {1'b0, pm} + {1'b0, nm};
                if (pm) begin
                    t_next    = AW'(idx_reg - CW'(1));
                    tent_next = '{id: prev_reg.id, free: 1'b1,
                                  size: prev_reg.size + cur_reg.size, offset: prev_reg.offset};
                end else begin
                    t_next    = idx_reg[AW-1:0];
                    tent_next = '{id: cur_reg.id, free: 1'b1, size: cur_reg.size,
                                  offset: cur_reg.offset};
                end
                mv_rd_next   = src_lo;
                mv_cnt_next  = count_reg - src_lo;
                mv_up_next   = 1'b1;
                mv_fr_next   = 1'b1;
                mv_pend_next = 1'b0;
                state_next   = ffsa_pkg::ST_F_ADD;
            end
            ffsa_pkg::ST_F_ADD: begin
                if (nm_reg) begin
                    tent_next.size = tent_reg.size + nxt_reg.size;
                end
                state_next = ffsa_pkg::ST_MOVE;
            end
            ffsa_pkg::ST_F_DONE: begin
                mem_we     = 1'b1;
                mem_waddr  = t_reg;
                mem_wdata  = tent_reg;
                count_next = count_reg - CW'(rm_reg);
                res_next   = '{status: ffsa_pkg::STATUS_OK, given_id: '0, offset: '0};
                state_next = ffsa_pkg::ST_RESP;
            end
            ffsa_pkg::ST_MOVE: begin
                mem_we    = mv_pend_reg;
                mem_waddr = mv_wa_reg;
                mem_wdata = mem_rdata;
                if (mv_cnt_reg != '0) begin
                    mem_raddr    = mv_rd_reg[AW-1:0];
                    mv_pend_next = 1'b1;
                    mv_wa_next   = mv_up_reg ? AW'(mv_rd_reg - CW'(rm_reg))
                                             : AW'(mv_rd_reg + CW'(1));
                    mv_rd_next   = mv_up_reg ? mv_rd_reg + CW'(1) : mv_rd_reg - CW'(1);
                    mv_cnt_next  = mv_cnt_reg - CW'(1);
                end else begin
                    mv_pend_next = 1'b0;
                    state_next   = mv_fr_reg ? ffsa_pkg::ST_F_DONE : ffsa_pkg::ST_A_SPLIT;
                end
            end
            ffsa_pkg::ST_RESP: begin
                res_valid = res_free;
                if (res_free) begin
                    state_next = ffsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffsa_pkg::ST_INIT;
            end
        endcase

        if (cfg_we) begin
            case (cfg_index)
                ffsa_pkg::CFG_PAGE_SIZE: begin
                    page_next  = cfg_data;
                    count_next = CW'(1);
                    idc_next   = ffsa_pkg::ID_W'(1);
                    state_next = ffsa_pkg::ST_INIT;
                end
                ffsa_pkg::CFG_GRANULARITY: begin
                    gran_next = cfg_data[ffsa_pkg::GRAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/ffsa_checker.sv @@
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module ffsa_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            cfg_we,
    input wire logic [ffsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ffsa_pkg::OUT_DATA_W-1:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ffsa_pkg::STATUS_OK) |-> (m_tdata[65:2] == '0))
        else $error("error result carries id or offset");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted on consecutive cycles");

    a_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == ffsa_pkg::CFG_PAGE_SIZE) |=> !s_tready)
        else $error("input open during table rebuild");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
`default_nettype wire

@@ test/tb_first_fit_segment_allocator.sv @@
// Self-checking testbench of the first-fit segment allocator: directed and random traffic.
`default_nettype none

class segment_table_model;
    logic [63:0] seg_off [64];
    logic [63:0] seg_len [64];
    bit          seg_avail [64];
    logic [31:0] seg_tag [64];
    int          seg_cnt;
    logic [31:0] next_tag;
    logic [63:0] page_bytes;
    logic [63:0] gran;
    ffsa_pkg::res_t expected_replies[$];
    logic [31:0] live_tags[$];
    int          mismatches;
    int          n_status[4];

    function new();
        page_bytes = 64'(ffsa_pkg::PAGE_SIZE_RESET);
        gran       = 64'd1;
        mismatches = 0;
        foreach (n_status[k]) n_status[k] = 0;
        rebuild();
    endfunction

    function void rebuild();
        seg_off[0]   = '0;
        seg_len[0]   = page_bytes;
        seg_avail[0] = 1'b1;
        seg_tag[0]   = '0;
        seg_cnt      = 1;
        next_tag     = 32'd1;
        live_tags.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == ffsa_pkg::CFG_PAGE_SIZE) begin
            page_bytes = 64'(val);
            rebuild();
        end else if (idx == ffsa_pkg::CFG_GRANULARITY) begin
            gran = 64'(val[16:0]);
        end
    endfunction

    function logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
        if (a == 0) a = 1;
        return (x + a - 1) & ~(a - 1);
    endfunction

    function bit shares_page(logic [63:0] a_off, logic [63:0] a_len, logic [63:0] b_off,
                             logic [63:0] g);
        logic [63:0] mask;
        mask = ~(g - 1);
        return ((a_off + a_len - 1) & mask) == (b_off & mask);
    endfunction

    function void copy_entry(int dst, int src);
        seg_off[dst]   = seg_off[src];
        seg_len[dst]   = seg_len[src];
        seg_avail[dst] = seg_avail[src];
        seg_tag[dst]   = seg_tag[src];
    endfunction

    function void drop_entry(int i);
        for (int k = i; k < seg_cnt - 1; k++) copy_entry(k, k + 1);
        seg_cnt--;
    endfunction

    function ffsa_pkg::res_t allocate(logic [63:0] req, logic [63:0] al);
        ffsa_pkg::res_t r;
        int i;
        logic [63:0] pad, padded;
        r = '0;
        pad = 0;
        padded = 0;
        for (i = 0; i < seg_cnt; i++) begin
            if (!seg_avail[i] || req > seg_len[i]) continue;
            pad = round_up(seg_off[i], al);
            if (i > 0 && gran > 1 && shares_page(seg_off[i-1], seg_len[i-1], pad, gran))
                pad = round_up(pad, gran);
            padded = req + (pad - seg_off[i]);
            if (padded > seg_len[i]) continue;
            if (gran > 1 && i + 1 < seg_cnt && shares_page(pad, req, seg_off[i+1], gran))
                continue;
            break;
        end
        if (i >= seg_cnt) begin
            r.status = ffsa_pkg::STATUS_NO_FIT;
            return r;
        end
        if (seg_len[i] > padded) begin
            if (seg_cnt >= 64) begin
                r.status = ffsa_pkg::STATUS_FULL;
                return r;
            end
            for (int k = seg_cnt; k > i + 1; k--) copy_entry(k, k - 1);
            seg_cnt++;
            seg_off[i+1]   = (seg_off[i] + padded) & 64'hFFFF_FFFF;
            seg_len[i+1]   = seg_len[i] - padded;
            seg_avail[i+1] = 1'b1;
            seg_tag[i+1]   = next_tag;
            next_tag++;
        end
        seg_len[i]   = padded;
        seg_avail[i] = 1'b0;
        r.status   = ffsa_pkg::STATUS_OK;
        r.given_id = seg_tag[i];
        r.offset   = pad[31:0];
        live_tags.insert(live_tags.size(), seg_tag[i]);
        return r;
    endfunction

    function ffsa_pkg::res_t release_tag(logic [31:0] tag);
        ffsa_pkg::res_t r;
        int i;
        r = '0;
        for (i = 0; i < seg_cnt; i++)
            if (seg_tag[i] == tag) break;
        if (i >= seg_cnt) begin
            r.status = ffsa_pkg::STATUS_NOT_FOUND;
            return r;
        end
        seg_avail[i] = 1'b1;
        if (i > 0 && seg_avail[i-1]) begin
            seg_len[i-1] += seg_len[i];
            drop_entry(i);
            i--;
        end
        if (i + 1 < seg_cnt && seg_avail[i+1]) begin
            seg_len[i] += seg_len[i+1];
            drop_entry(i + 1);
        end
        for (int k = live_tags.size() - 1; k >= 0; k--)
            if (live_tags[k] == tag) live_tags.delete(k);
        r.status = ffsa_pkg::STATUS_OK;
        return r;
    endfunction

    function void note_request(logic fn, logic [31:0] req, logic [16:0] al, logic [31:0] tag);
        ffsa_pkg::res_t r;
        if (fn == ffsa_pkg::FUNC_ALLOC) r = allocate(64'(req), 64'(al));
        else r = release_tag(tag);
        n_status[r.status]++;
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void check_reply(logic [ffsa_pkg::OUT_DATA_W-1:0] word);
        ffsa_pkg::res_t want, got;
        got.status   = word[1:0];
        got.given_id = word[33:2];
        got.offset   = word[65:34];
        if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reply %h", word);
            return;
        end
        want = expected_replies.pop_front();
        if (got !== want || word[71:66] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply mismatch: expected st=%0d id=%h off=%h, got st=%0d id=%h off=%h",
                         want.status, want.given_id, want.offset,
                         got.status, got.given_id, got.offset);
        end
    endfunction

    function int pending();
        return expected_replies.size();
    endfunction
endclass

module tb_first_fit_segment_allocator;
    localparam logic [ffsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ffsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [ffsa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ffsa_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ffsa_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ffsa_pkg::OUT_DATA_W-1:0] m_tdata;

    segment_table_model tbl;
    bit calm;
    int cycles;
    int words_sent;

    first_fit_segment_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 3000000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stall bursts, none once calm
    initial begin : sink
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) tbl.check_reply(m_tdata);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic fn, logic [31:0] req, logic [16:0] al, logic [31:0] tag);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'b0, tag, al, req};
        do @(posedge aclk); while (!s_tready);
        tbl.note_request(fn, req, al, tag);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tbl.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ffsa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tbl.set_reg(idx, val);
        repeat (3) @(posedge aclk);
    endtask

    task automatic run_phase(logic [31:0] page, logic [16:0] g, int n, int max_len,
                             int free_pct, bit last_phase);
        logic [31:0] req, tag;
        logic [16:0] al;
        int r;
        write_reg(ffsa_pkg::CFG_PAGE_SIZE, page);
        write_reg(ffsa_pkg::CFG_GRANULARITY, 32'(g));
        for (int k = 0; k < n; k++) begin
            if (last_phase && k >= n - 80) calm = 1'b1;
            if ($urandom_range(0, 99) < free_pct) begin
                if (tbl.live_tags.size() > 0 && $urandom_range(0, 9) < 8)
                    tag = tbl.live_tags[$urandom_range(0, tbl.live_tags.size() - 1)];
                else if ($urandom_range(0, 1) == 0)
                    tag = $urandom_range(0, tbl.next_tag);
                else
                    tag = $urandom;
                send_word(ffsa_pkg::FUNC_FREE, $urandom, 17'($urandom), tag);
            end else begin
                r = $urandom_range(0, 19);
                if (r == 0) req = $urandom;
                else if (r == 1) req = 32'd0;
                else req = $urandom_range(1, max_len);
                if ($urandom_range(0, 9) == 0) al = 17'($urandom_range(1, 65536));
                else al = 17'(1) << $urandom_range(0, $urandom_range(0, 16));
                send_word(ffsa_pkg::FUNC_ALLOC, req, al, $urandom);
            end
        end
    endtask

    initial begin
        tbl        = new();
        calm       = 1'b0;
        words_sent = 0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (5) @(posedge aclk);

        // directed: reset page first, then extremes and error codes
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd0, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd100, 17'd65536, 32'hFFFF_FFFF);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd7, 17'd3, '0);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'hFFFF_FFFF);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'd2);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'd2);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'd0);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'd0);
        write_reg(ffsa_pkg::CFG_GRANULARITY, 32'd65536);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd10, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd10, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'd0);
        write_reg(ffsa_pkg::CFG_PAGE_SIZE, 32'd1);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd1, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'd1, 17'd1, '0);
        write_reg(ffsa_pkg::CFG_PAGE_SIZE, 32'hFFFF_FFFF);
        write_reg(ffsa_pkg::CFG_GRANULARITY, 32'd1);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 17'd1, '0);
        send_word(ffsa_pkg::FUNC_FREE, '0, '0, 32'd0);
        send_word(ffsa_pkg::FUNC_ALLOC, 32'h8000_0000, 17'd65536, '0);

        run_phase(32'd65536, 17'd1, 150, 64, 20, 1'b0);
        run_phase(32'd4096, 17'd16, 120, 256, 40, 1'b0);
        run_phase(32'd1000000, 17'd256, 120, 50000, 40, 1'b0);
        run_phase(32'hFFFF_FFFF, 17'd65536, 120, 32'h0800_0000, 40, 1'b0);
        run_phase(32'd777, 17'd3, 100, 40, 35, 1'b0);
        run_phase(32'd8, 17'd0, 60, 3, 40, 1'b0);
        run_phase(32'd262144, 17'd4096, 160, 9000, 45, 1'b1);

        drain();
        repeat (200) @(posedge aclk);
        $display("%0d requests: %0d ok, %0d no fit, %0d table full, %0d unknown id",
                 words_sent, tbl.n_status[ffsa_pkg::STATUS_OK],
                 tbl.n_status[ffsa_pkg::STATUS_NO_FIT],
                 tbl.n_status[ffsa_pkg::STATUS_FULL],
                 tbl.n_status[ffsa_pkg::STATUS_NOT_FOUND]);
        $display("pages from 1 byte to 4 GiB, granularity 0 to 65536; %0d mismatches",
                 tbl.mismatches);
        if (tbl.mismatches == 0 && tbl.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
hdl/ffsa_pkg.sv
hdl/ffsa_mem.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator.sv
hdl/ffsa_checker.sv
test/tb_first_fit_segment_allocator.sv
